// ===== rtl/modular_exponentiation_defines.svh =====
// assertion macros for the modular exponentiation block
// no dependencies; included by the top level only
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTHESIS
`define ME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_exponentiation: check failed");
`define ME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_exponentiation: check failed");
`else
`define ME_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mexp_pkg.sv =====
// shared types, microcode encoding and control store of the modular exponentiation block
// no dependencies
`default_nettype none

package mexp_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic [DATA_W-1:0] base_value;
        logic [DATA_W-1:0] exponent;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] power_result;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RED_SET,
        S_RED_RUN,
        S_RED_WR,
        S_BIT_TST,
        S_MUL_SET,
        S_MUL_RUN,
        S_MUL_WR,
        S_SQ_SET,
        S_SQ_RUN,
        S_SQ_WR,
        S_DONE
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_REQ,
        C_MOD_SMALL,
        C_CNT_NZ,
        C_EXP_ZERO,
        C_EBIT_ZERO,
        C_EXP_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [1:0] {
        OPA_ONE,
        OPA_ACC,
        OPA_SQ
    } t_opa;

    typedef enum logic {
        OPB_BASE,
        OPB_SQ
    } t_opb;

    typedef struct packed {
        logic  in_rdy;
        logic  acc_init;
        logic  mul_setup;
        t_opa  opa;
        t_opb  opb;
        logic  mul_step;
        logic  wr_acc;
        logic  wr_sq;
        logic  exp_shift;
        logic  out_load;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_ctrl;

    // control store: jump to jmp when cond holds, else go to nxt
    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl w;
        w = '0;
        unique case (step)
            S_IDLE: begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_REQ;
                w.jmp    = S_IDLE;
                w.nxt    = S_INIT;
            end
            S_INIT: begin
                w.acc_init = 1'b1;
                w.cond     = C_MOD_SMALL;
                w.jmp      = S_DONE;
                w.nxt      = S_RED_SET;
            end
            S_RED_SET: begin
                w.mul_setup = 1'b1;
                w.opa       = OPA_ONE;
                w.opb       = OPB_BASE;
                w.cond      = C_ALWAYS;
                w.jmp       = S_RED_RUN;
                w.nxt       = S_RED_RUN;
            end
            S_RED_RUN: begin
                w.mul_step = 1'b1;
                w.cond     = C_CNT_NZ;
                w.jmp      = S_RED_RUN;
                w.nxt      = S_RED_WR;
            end
            S_RED_WR: begin
                w.wr_sq = 1'b1;
                w.cond  = C_EXP_ZERO;
                w.jmp   = S_DONE;
                w.nxt   = S_BIT_TST;
            end
            S_BIT_TST: begin
                w.cond = C_EBIT_ZERO;
                w.jmp  = S_SQ_SET;
                w.nxt  = S_MUL_SET;
            end
            S_MUL_SET: begin
                w.mul_setup = 1'b1;
                w.opa       = OPA_ACC;
                w.opb       = OPB_SQ;
                w.cond      = C_ALWAYS;
                w.jmp       = S_MUL_RUN;
                w.nxt       = S_MUL_RUN;
            end
            S_MUL_RUN: begin
                w.mul_step = 1'b1;
                w.cond     = C_CNT_NZ;
                w.jmp      = S_MUL_RUN;
                w.nxt      = S_MUL_WR;
            end
            S_MUL_WR: begin
                w.wr_acc = 1'b1;
                w.cond   = C_EXP_MORE;
                w.jmp    = S_SQ_SET;
                w.nxt    = S_DONE;
            end
            S_SQ_SET: begin
                w.mul_setup = 1'b1;
                w.opa       = OPA_SQ;
                w.opb       = OPB_SQ;
                w.cond      = C_ALWAYS;
                w.jmp       = S_SQ_RUN;
                w.nxt       = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                w.mul_step = 1'b1;
                w.cond     = C_CNT_NZ;
                w.jmp      = S_SQ_RUN;
                w.nxt      = S_SQ_WR;
            end
            S_SQ_WR: begin
                w.wr_sq     = 1'b1;
                w.exp_shift = 1'b1;
                w.cond      = C_EXP_MORE;
                w.jmp       = S_BIT_TST;
                w.nxt       = S_DONE;
            end
            S_DONE: begin
                w.out_load = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.jmp      = S_DONE;
                w.nxt      = S_IDLE;
            end
            default: begin
                w.cond = C_ALWAYS;
                w.jmp  = S_IDLE;
                w.nxt  = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mexp_if.sv =====
// valid/ready channel interfaces for requests and results
// depends on mexp_pkg
`default_nettype none

interface mexp_req_if;
    import mexp_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mexp_rsp_if;
    import mexp_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// modular exponentiation: microcoded square-and-multiply with a shift-add modular multiplier
// depends on mexp_pkg, mexp_if and modular_exponentiation_defines.svh
//
//  channel  | dir | payload                      | handshake
//  ---------+-----+------------------------------+-------------
//  i_req    | in  | base_value, exponent         | valid/ready
//  o_rsp    | out | power_result                 | valid/ready
//  cfg      | in  | i_cfg_wr_data (modulus)      | i_cfg_wr_en
//
// one request at a time; a modular multiply runs the set, run and write steps of the shift-add unit
// the base is first reduced by one multiply; then per exponent bit up to the top set one a multiply
// if the bit is set and a squaring, the top bit skipping its squaring
// loop skipped when the modulus is below two; next request taken in the idle step after the result
// the result waits in an output register; the done step holds while the previous one is unread
// synchronous active-low reset; modulus resets to 2
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [mexp_pkg::DATA_W-1:0] i_cfg_wr_data,
    mexp_req_if.sink                     i_req,
    mexp_rsp_if.source                   o_rsp
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;

    logic [DATA_W-1:0] r_modulus;
    logic [WIDTH-1:0]  r_mod;
    logic [WIDTH-1:0]  r_base;
    logic [WIDTH-1:0]  r_exp;
    logic [WIDTH-1:0]  r_acc;
    logic [WIDTH-1:0]  r_sq;
    logic [WIDTH-1:0]  r_mul_a;
    logic [WIDTH-1:0]  r_mul_b;
    logic [WIDTH-1:0]  r_prod;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [WIDTH-1:0]  r_out_data;

    logic             cond_hit;
    logic             req_fire;
    logic             out_busy;
    logic             out_go;
    logic             mod_small;
    logic [WIDTH-1:0] opa_val;
    logic [WIDTH-1:0] opb_val;
    logic [WIDTH+1:0] mul_sum;
    logic [WIDTH+1:0] mod_x1;
    logic [WIDTH+1:0] mod_x2;
    logic [WIDTH+1:0] mul_red;
    logic [WIDTH-1:0] mul_next;

    // control decode
    always_comb begin
        ctrl        = ctrl_rom(r_step);
        i_req.ready = ctrl.in_rdy;
        req_fire    = i_req.valid && ctrl.in_rdy;
        out_busy    = r_out_valid && !o_rsp.ready;
        out_go      = ctrl.out_load && !out_busy;
        mod_small   = (r_mod[WIDTH-1:1] == '0);
    end

    always_comb begin
        unique case (ctrl.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_REQ:    cond_hit = !i_req.valid;
            C_MOD_SMALL: cond_hit = mod_small;
            C_CNT_NZ:    cond_hit = (r_cnt != '0);
            C_EXP_ZERO:  cond_hit = (r_exp == '0);
            C_EBIT_ZERO: cond_hit = !r_exp[0];
            C_EXP_MORE:  cond_hit = (r_exp[WIDTH-1:1] != '0);
            C_OUT_BUSY:  cond_hit = out_busy;
            default:     cond_hit = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_step = cond_hit ? ctrl.jmp : ctrl.nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= DATA_W'(2);
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // operand selection
    always_comb begin
        unique case (ctrl.opa)
            OPA_ONE: opa_val = WIDTH'(1);
            OPA_ACC: opa_val = r_acc;
            OPA_SQ:  opa_val = r_sq;
            default: opa_val = r_acc;
        endcase
        unique case (ctrl.opb)
            OPB_BASE: opb_val = r_base;
            OPB_SQ:   opb_val = r_sq;
            default:  opb_val = r_sq;
        endcase
    end

    // one multiplier bit per cycle: prod = 2*prod + bit*a, then reduce from below 3m
    always_comb begin
        mul_sum = {1'b0, r_prod, 1'b0} + {2'b00, (r_mul_b[WIDTH-1] ? r_mul_a : '0)};
        mod_x1  = {2'b00, r_mod};
        mod_x2  = {1'b0, r_mod, 1'b0};
        priority if (mul_sum >= mod_x2) begin
            mul_red = mul_sum - mod_x2;
        end else if (mul_sum >= mod_x1) begin
            mul_red = mul_sum - mod_x1;
        end else begin
            mul_red = mul_sum;
        end
        mul_next = mul_red[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_base <= i_req.payload.base_value[WIDTH-1:0];
            r_exp  <= i_req.payload.exponent[WIDTH-1:0];
            r_mod  <= r_modulus[WIDTH-1:0];
        end
        if (ctrl.acc_init) begin
            r_acc <= mod_small ? '0 : WIDTH'(1);
        end
        if (ctrl.mul_setup) begin
            r_mul_a <= opa_val;
            r_mul_b <= opb_val;
            r_prod  <= '0;
            r_cnt   <= CNT_W'(WIDTH - 1);
        end
        if (ctrl.mul_step) begin
            r_prod  <= mul_next;
            r_mul_b <= {r_mul_b[WIDTH-2:0], 1'b0};
            r_cnt   <= r_cnt - 1'b1;
        end
        if (ctrl.wr_acc) begin
            r_acc <= r_prod;
        end
        if (ctrl.wr_sq) begin
            r_sq <= r_prod;
        end
        if (ctrl.exp_shift) begin
            r_exp <= {1'b0, r_exp[WIDTH-1:1]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_go) begin
            r_out_data <= r_acc;
        end
    end

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.payload.power_result = DATA_W'(r_out_data);

    `ME_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, req_fire, r_step == S_INIT)
    `ME_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_go, r_out_valid)
    `ME_ASSERT_IMPL(a_prod_reduced, i_clk, i_rst_n,
        (r_step == S_RED_RUN || r_step == S_MUL_RUN || r_step == S_SQ_RUN), r_prod < r_mod)
    `ME_ASSERT_IMPL(a_acc_reduced, i_clk, i_rst_n, r_step == S_BIT_TST,
        (r_acc < r_mod) && (r_sq < r_mod))

endmodule

`default_nettype wire
